// File: hw/rtl/bounded_sorted_beam_queue_core_macros.svh
// Assertion macros shared by the beam queue checker.
`ifndef BOUNDED_SORTED_BEAM_QUEUE_CORE_MACROS_SVH
`define BOUNDED_SORTED_BEAM_QUEUE_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BSBQ_ASSERT_IMP(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error("bsbq: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define BSBQ_ASSERT_NXT(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error("bsbq: next-cycle check failed");

`endif

// File: hw/rtl/bsbq_pkg.sv
// Package: types, codes and defaults of the bounded sorted beam queue.
`timescale 1ns / 1ps
package bsbq_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int TAG_BITS_DEF   = 16;
  localparam int SCORE_BITS_DEF = 32;

  localparam int LIMIT_BITS    = 5;
  localparam int INST_BITS     = 16;
  localparam int KIND_BITS     = 3;
  localparam int CFG_ADDR_BITS = 4;
  localparam int CFG_DATA_BITS = 32;
  localparam int REG_IDX_BITS  = CFG_ADDR_BITS - 2;

  localparam logic [LIMIT_BITS-1:0] BEAM_LIMIT_RST    = LIMIT_BITS'(4);
  localparam logic                  LIMIT_BY_DIST_RST = 1'b0;
  localparam logic [INST_BITS-1:0]  MIN_INST_RST      = '0;

  // register indexes on the config port
  localparam logic [REG_IDX_BITS-1:0] REG_BEAM_LIMIT    = REG_IDX_BITS'(0);
  localparam logic [REG_IDX_BITS-1:0] REG_LIMIT_BY_DIST = REG_IDX_BITS'(1);
  localparam logic [REG_IDX_BITS-1:0] REG_MIN_INST      = REG_IDX_BITS'(2);

  // request opcodes
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_POP    = 1'b1;

  typedef enum logic [KIND_BITS-1:0] {
    K_STORED  = 3'd0,
    K_BELOW   = 3'd1,
    K_BEYOND  = 3'd2,
    K_EVICTED = 3'd3,
    K_POPPED  = 3'd4,
    K_EMPTY   = 3'd5
  } kind_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_SRCH_RD,
    S_SRCH_EQ,
    S_SRCH_GT,
    S_SRCH_END,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_POP_RD,
    S_POP_HEAD,
    S_PSH_RD,
    S_PSH_WR,
    S_SCAN_RD,
    S_SCAN_EV,
    S_FINAL,
    S_EMIT_FIRST,
    S_EMIT_RD,
    S_EMIT_EV
  } state_t;

endpackage

// File: hw/rtl/bounded_sorted_beam_queue_core.sv
// Top level: bounded sorted beam queue with a sequenced one-read, one-write entry store.
// Usage:
//  - Request channel: present in_op and the item fields, raise start; the
//    request is taken on the edge where start is high and busy is low.
//    busy stays high until the cycle in which the last result is shown.
//  - Result channel: each result shows for one cycle with out_valid high;
//    out_last marks the final result of a request. The receiver cannot
//    stall, so the block never holds a result back.
//  - Config: APB-style writes to beam_limit (0x0), limit_by_distinct (0x4)
//    and min_instances (0x8); pready is tied high. Write only while idle.
//  - An insert takes longer with more entries held and evicted, a pop with
//    more entries held. The time is set by the entry store (one read and
//    one write per cycle) and the one shared score comparator that search
//    and the distinct-count scan take turns on.
//  - Reset (synchronous, rst_n low) empties the beam and restores the
//    register defaults; the entry store itself is not cleared.
`timescale 1ns / 1ps
module bounded_sorted_beam_queue_core
  import bsbq_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int TAG_BITS   = TAG_BITS_DEF,
  parameter int SCORE_BITS = SCORE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // request channel
  input  logic                         start,
  output logic                         busy,
  input  logic                         in_op,
  input  logic [TAG_BITS-1:0]          in_item_tag,
  input  logic signed [SCORE_BITS-1:0] in_score,
  input  logic [INST_BITS-1:0]         in_instance_count,
  // result channel
  output logic                         out_valid,
  output logic [KIND_BITS-1:0]         out_kind,
  output logic [TAG_BITS-1:0]          out_tag,
  output logic signed [SCORE_BITS-1:0] out_score,
  output logic                         out_new_kept,
  output logic [$clog2(DEPTH+1)-1:0]   out_entry_count,
  output logic [$clog2(DEPTH+1)-1:0]   out_distinct_count,
  output logic                         out_last,
  // config port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [CFG_ADDR_BITS-1:0]     paddr,
  input  logic [CFG_DATA_BITS-1:0]     pwdata,
  output logic [CFG_DATA_BITS-1:0]     prdata,
  output logic                         pready
);

  // AW: store address (DEPTH+1 slots, one spare for the overflow entry)
  // CW: working counts, up to DEPTH+1
  // OW: counts held between requests, up to DEPTH
  localparam int AW = $clog2(DEPTH + 1);
  localparam int CW = $clog2(DEPTH + 2);
  localparam int OW = $clog2(DEPTH + 1);
  localparam int LW = (CW > LIMIT_BITS) ? CW : LIMIT_BITS;

  // ---------------------------------------------------------------------
  // config registers
  // ---------------------------------------------------------------------
  logic [LIMIT_BITS-1:0] beam_limit_r;
  logic                  limit_by_distinct_r;
  logic [INST_BITS-1:0]  min_instances_r;
  logic                  cfg_wr;
  logic [REG_IDX_BITS-1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[CFG_ADDR_BITS-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beam_limit_r        <= BEAM_LIMIT_RST;
      limit_by_distinct_r <= LIMIT_BY_DIST_RST;
      min_instances_r     <= MIN_INST_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_BEAM_LIMIT:    beam_limit_r        <= pwdata[LIMIT_BITS-1:0];
        REG_LIMIT_BY_DIST: limit_by_distinct_r <= pwdata[0];
        REG_MIN_INST:      min_instances_r     <= pwdata[INST_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_BEAM_LIMIT:    prdata = CFG_DATA_BITS'(beam_limit_r);
      REG_LIMIT_BY_DIST: prdata = CFG_DATA_BITS'(limit_by_distinct_r);
      REG_MIN_INST:      prdata = CFG_DATA_BITS'(min_instances_r);
      default:           prdata = '0;
    endcase
  end

  // a limit of zero behaves as one
  logic [LW-1:0] lim;
  assign lim = (beam_limit_r == '0) ? LW'(1) : LW'(beam_limit_r);

  // ---------------------------------------------------------------------
  // entry store: one write and one registered read per cycle
  // ---------------------------------------------------------------------
  logic [TAG_BITS-1:0]          mem_tag   [DEPTH+1];
  logic signed [SCORE_BITS-1:0] mem_score [DEPTH+1];
  logic                         mem_we;
  logic [AW-1:0]                mem_waddr;
  logic [AW-1:0]                mem_raddr;
  logic [TAG_BITS-1:0]          mem_wtag;
  logic signed [SCORE_BITS-1:0] mem_wscore;
  logic [TAG_BITS-1:0]          rd_tag_r;
  logic signed [SCORE_BITS-1:0] rd_score_r;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_tag[mem_waddr]   <= mem_wtag;
      mem_score[mem_waddr] <= mem_wscore;
    end
    rd_tag_r   <= mem_tag[mem_raddr];
    rd_score_r <= mem_score[mem_raddr];
  end

  // ---------------------------------------------------------------------
  // sequencer registers
  // ---------------------------------------------------------------------
  state_t                       state_r, state_nxt;
  logic [OW-1:0]                held_r, held_nxt;      // entries held
  logic [OW-1:0]                dist_r, dist_nxt;      // distinct scores held
  logic [TAG_BITS-1:0]          tag_r, tag_nxt;        // request tag / popped head
  logic signed [SCORE_BITS-1:0] score_r, score_nxt;
  kind_t                        kind_r, kind_nxt;      // kind of the first result
  logic                         kept_r, kept_nxt;
  logic [CW-1:0]                idx_r, idx_nxt;        // walk pointer
  logic [CW-1:0]                p_r, p_nxt;            // insert position
  logic [CW-1:0]                d_r, d_nxt;            // distinct counter
  logic [CW-1:0]                s_r, s_nxt;            // start of lowest group
  logic [CW-1:0]                h_r, h_nxt;            // count before trimming
  logic [CW-1:0]                ev_idx_r, ev_idx_nxt;  // next evicted slot
  logic signed [SCORE_BITS-1:0] prev_r, prev_nxt;      // previous score in walk
  logic                         grp_start_r, grp_start_nxt;

  logic                         out_valid_r, out_valid_nxt;
  kind_t                        out_kind_r, out_kind_nxt;
  logic [TAG_BITS-1:0]          out_tag_r, out_tag_nxt;
  logic signed [SCORE_BITS-1:0] out_score_r, out_score_nxt;
  logic                         out_kept_r, out_kept_nxt;
  logic [OW-1:0]                out_cnt_r, out_cnt_nxt;
  logic [OW-1:0]                out_dist_r, out_dist_nxt;
  logic                         out_last_r, out_last_nxt;

  // shared score comparator: stored score against the request score in the
  // search's greater-than step, against the previous stored score otherwise
  logic signed [SCORE_BITS-1:0] cmp_b;
  logic                         cmp_gt;
  logic                         cmp_eq;

  assign cmp_b  = (state_r == S_SRCH_GT) ? score_r : prev_r;
  assign cmp_gt = rd_score_r > cmp_b;
  assign cmp_eq = rd_score_r == cmp_b;

  logic [CW-1:0] idx_m1;
  logic [CW-1:0] h_m1;
  assign idx_m1 = idx_r - CW'(1);
  assign h_m1   = h_r - CW'(1);

  // trimming after an insert or pop
  logic [CW-1:0] hf_c;
  logic [CW-1:0] df_c;
  logic          rm_c;
  logic          single_c;

  always_comb begin
    rm_c     = (LW'(h_r) > lim) || (h_r > CW'(DEPTH));
    single_c = (s_r == h_m1);   // lowest group is one entry
    hf_c     = h_r;
    df_c     = d_r;
    if (kind_r == K_POPPED) begin
      hf_c = h_r;
      df_c = d_r;
    end else if (!limit_by_distinct_r) begin
      if (rm_c) begin
        hf_c = h_m1;
        df_c = single_c ? d_r - CW'(1) : d_r;
      end
    end else if (LW'(d_r) > lim) begin
      // drop the whole lowest-score group
      hf_c = s_r;
      df_c = d_r - CW'(1);
    end else if (h_r > CW'(DEPTH)) begin
      hf_c = h_m1;
      df_c = single_c ? d_r - CW'(1) : d_r;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    held_nxt      = held_r;
    dist_nxt      = dist_r;
    tag_nxt       = tag_r;
    score_nxt     = score_r;
    kind_nxt      = kind_r;
    kept_nxt      = kept_r;
    idx_nxt       = idx_r;
    p_nxt         = p_r;
    d_nxt         = d_r;
    s_nxt         = s_r;
    h_nxt         = h_r;
    ev_idx_nxt    = ev_idx_r;
    prev_nxt      = prev_r;
    grp_start_nxt = grp_start_r;

    out_valid_nxt = 1'b0;
    out_kind_nxt  = out_kind_r;
    out_tag_nxt   = out_tag_r;
    out_score_nxt = out_score_r;
    out_kept_nxt  = out_kept_r;
    out_cnt_nxt   = out_cnt_r;
    out_dist_nxt  = out_dist_r;
    out_last_nxt  = out_last_r;

    mem_we     = 1'b0;
    mem_waddr  = idx_r[AW-1:0];
    mem_wtag   = rd_tag_r;
    mem_wscore = rd_score_r;
    mem_raddr  = idx_r[AW-1:0];

    case (state_r)
      S_IDLE: begin
        if (start) begin
          tag_nxt    = in_item_tag;
          score_nxt  = in_score;
          kept_nxt   = 1'b0;
          h_nxt      = CW'(held_r);
          ev_idx_nxt = CW'(held_r);
          idx_nxt    = '0;
          d_nxt      = '0;
          if (in_op == OP_POP) begin
            if (held_r == '0) begin
              kind_nxt  = K_EMPTY;
              tag_nxt   = '0;
              score_nxt = '0;
              state_nxt = S_EMIT_FIRST;
            end else begin
              kind_nxt  = K_POPPED;
              state_nxt = S_POP_RD;
            end
          end else if (in_instance_count < min_instances_r) begin
            kind_nxt  = K_BELOW;
            state_nxt = S_EMIT_FIRST;
          end else begin
            kind_nxt  = K_STORED;
            state_nxt = S_SRCH_RD;
          end
        end
      end

      // walk past entries strictly above the new score
      S_SRCH_RD: begin
        if (idx_r == CW'(held_r)) begin
          state_nxt = S_SRCH_END;
        end else begin
          state_nxt = S_SRCH_EQ;
        end
      end

      S_SRCH_EQ: begin
        grp_start_nxt = (idx_r == '0) || !cmp_eq;
        state_nxt     = S_SRCH_GT;
      end

      S_SRCH_GT: begin
        if (cmp_gt) begin
          if (grp_start_r) begin
            d_nxt = d_r + CW'(1);
          end
          prev_nxt  = rd_score_r;
          idx_nxt   = idx_r + CW'(1);
          state_nxt = S_SRCH_RD;
        end else begin
          state_nxt = S_SRCH_END;
        end
      end

      S_SRCH_END: begin
        p_nxt = idx_r;
        if (limit_by_distinct_r && (LW'(d_r) >= lim)) begin
          kind_nxt  = K_BEYOND;
          state_nxt = S_EMIT_FIRST;
        end else begin
          idx_nxt   = CW'(held_r);
          state_nxt = S_SHIFT_RD;
        end
      end

      // open a slot at p, moving the tail down one entry at a time
      S_SHIFT_RD: begin
        if (idx_r == p_r) begin
          mem_we     = 1'b1;
          mem_waddr  = p_r[AW-1:0];
          mem_wtag   = tag_r;
          mem_wscore = score_r;
          h_nxt      = CW'(held_r) + CW'(1);
          idx_nxt    = '0;
          d_nxt      = '0;
          s_nxt      = '0;
          state_nxt  = S_SCAN_RD;
        end else begin
          mem_raddr = idx_m1[AW-1:0];
          state_nxt = S_SHIFT_WR;
        end
      end

      S_SHIFT_WR: begin
        mem_we    = 1'b1;
        mem_waddr = idx_r[AW-1:0];
        idx_nxt   = idx_m1;
        state_nxt = S_SHIFT_RD;
      end

      // pop: grab the head, then move everything up
      S_POP_RD: begin
        mem_raddr = '0;
        state_nxt = S_POP_HEAD;
      end

      S_POP_HEAD: begin
        tag_nxt   = rd_tag_r;
        score_nxt = rd_score_r;
        idx_nxt   = CW'(1);
        state_nxt = S_PSH_RD;
      end

      S_PSH_RD: begin
        if (idx_r == CW'(held_r)) begin
          h_nxt     = CW'(held_r) - CW'(1);
          idx_nxt   = '0;
          d_nxt     = '0;
          s_nxt     = '0;
          state_nxt = S_SCAN_RD;
        end else begin
          state_nxt = S_PSH_WR;
        end
      end

      S_PSH_WR: begin
        mem_we    = 1'b1;
        mem_waddr = idx_m1[AW-1:0];
        idx_nxt   = idx_r + CW'(1);
        state_nxt = S_PSH_RD;
      end

      // count distinct scores and find where the lowest group starts
      S_SCAN_RD: begin
        if (idx_r == h_r) begin
          state_nxt = S_FINAL;
        end else begin
          state_nxt = S_SCAN_EV;
        end
      end

      S_SCAN_EV: begin
        if ((idx_r == '0) || !cmp_eq) begin
          d_nxt = d_r + CW'(1);
          s_nxt = idx_r;
        end
        prev_nxt  = rd_score_r;
        idx_nxt   = idx_r + CW'(1);
        state_nxt = S_SCAN_RD;
      end

      S_FINAL: begin
        held_nxt   = hf_c[OW-1:0];
        dist_nxt   = df_c[OW-1:0];
        ev_idx_nxt = hf_c;
        kept_nxt   = (kind_r == K_STORED) && (p_r < hf_c);
        state_nxt  = S_EMIT_FIRST;
      end

      S_EMIT_FIRST: begin
        out_valid_nxt = 1'b1;
        out_kind_nxt  = kind_r;
        out_tag_nxt   = tag_r;
        out_score_nxt = score_r;
        out_kept_nxt  = kept_r;
        out_cnt_nxt   = held_r;
        out_dist_nxt  = dist_r;
        out_last_nxt  = (ev_idx_r == h_r);
        state_nxt     = (ev_idx_r == h_r) ? S_IDLE : S_EMIT_RD;
      end

      // evicted entries still sit past the new count in the store
      S_EMIT_RD: begin
        mem_raddr = ev_idx_r[AW-1:0];
        state_nxt = S_EMIT_EV;
      end

      S_EMIT_EV: begin
        out_valid_nxt = 1'b1;
        out_kind_nxt  = K_EVICTED;
        out_tag_nxt   = rd_tag_r;
        out_score_nxt = rd_score_r;
        out_kept_nxt  = kept_r;
        out_cnt_nxt   = held_r;
        out_dist_nxt  = dist_r;
        out_last_nxt  = (ev_idx_r == h_m1);
        ev_idx_nxt    = ev_idx_r + CW'(1);
        state_nxt     = (ev_idx_r == h_m1) ? S_IDLE : S_EMIT_RD;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      held_r      <= '0;
      dist_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      held_r      <= held_nxt;
      dist_r      <= dist_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tag_r       <= tag_nxt;
    score_r     <= score_nxt;
    kind_r      <= kind_nxt;
    kept_r      <= kept_nxt;
    idx_r       <= idx_nxt;
    p_r         <= p_nxt;
    d_r         <= d_nxt;
    s_r         <= s_nxt;
    h_r         <= h_nxt;
    ev_idx_r    <= ev_idx_nxt;
    prev_r      <= prev_nxt;
    grp_start_r <= grp_start_nxt;
    out_kind_r  <= out_kind_nxt;
    out_tag_r   <= out_tag_nxt;
    out_score_r <= out_score_nxt;
    out_kept_r  <= out_kept_nxt;
    out_cnt_r   <= out_cnt_nxt;
    out_dist_r  <= out_dist_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign busy               = (state_r != S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_kind           = out_kind_r;
  assign out_tag            = out_tag_r;
  assign out_score          = out_score_r;
  assign out_new_kept       = out_kept_r;
  assign out_entry_count    = out_cnt_r;
  assign out_distinct_count = out_dist_r;
  assign out_last           = out_last_r;

endmodule

// File: hw/rtl/bsbq_checker.sv
// Port-level checker for the beam queue core, with its bind.
`timescale 1ns / 1ps
`include "bounded_sorted_beam_queue_core_macros.svh"
module bsbq_checker
  import bsbq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       start,
  input logic                       busy,
  input logic                       out_valid,
  input logic [KIND_BITS-1:0]       out_kind,
  input logic                       out_new_kept,
  input logic [$clog2(DEPTH+1)-1:0] out_entry_count,
  input logic [$clog2(DEPTH+1)-1:0] out_distinct_count,
  input logic                       out_last
);

  // a taken request keeps the block busy
  `BSBQ_ASSERT_NXT(a_accept_busy, clk, rst_n, start && !busy, busy)

  // results only come out of a running request
  `BSBQ_ASSERT_IMP(a_result_in_request, clk, rst_n, out_valid, $past(busy))

  // counts stay within the store and distinct never exceeds entries
  `BSBQ_ASSERT_IMP(a_counts, clk, rst_n, out_valid,
                   (out_entry_count <= DEPTH) && (out_distinct_count <= out_entry_count))

  // pops and rejections never claim the item was kept
  `BSBQ_ASSERT_IMP(a_kept_kind, clk, rst_n,
                   out_valid && (out_kind != K_STORED) && (out_kind != K_EVICTED),
                   !out_new_kept)

  // the next request's first result cannot follow the last one directly
  `BSBQ_ASSERT_NXT(a_last_gap, clk, rst_n, out_valid && out_last, !out_valid)

endmodule

bind bounded_sorted_beam_queue_core bsbq_checker #(
  .DEPTH(DEPTH)
) u_bsbq_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .start              (start),
  .busy               (busy),
  .out_valid          (out_valid),
  .out_kind           (out_kind),
  .out_new_kept       (out_new_kept),
  .out_entry_count    (out_entry_count),
  .out_distinct_count (out_distinct_count),
  .out_last           (out_last)
);

// File: sim/bounded_sorted_beam_queue_core_test.sv
// Self-checking testbench for the bounded sorted beam queue core.
`timescale 1ns / 1ps
module bounded_sorted_beam_queue_core_test;
  import bsbq_pkg::*;

  localparam int TAG_W         = TAG_BITS_DEF;
  localparam int SCORE_W       = SCORE_BITS_DEF;
  localparam int BEAM_DEPTH    = DEPTH_DEF;
  localparam int CNT_W         = $clog2(DEPTH_DEF + 1);
  localparam int SETTLE_CYCLES = 8;
  // watchdog bound; the fewer than two hundred requests of this test, with
  // their evictions, fit far inside this
  localparam int CYCLE_LIMIT   = 400000;

  localparam logic signed [SCORE_W-1:0] SCORE_MAX = 32'sh7fff_ffff;
  localparam logic signed [SCORE_W-1:0] SCORE_MIN = 32'sh8000_0000;

  // one request as the driver sees it; hold_for_drain makes the driver wait
  // until every predicted result has come back before presenting it
  typedef struct {
    logic                      op;
    logic [TAG_W-1:0]          tag;
    logic signed [SCORE_W-1:0] score;
    logic [INST_BITS-1:0]      inst;
    bit                        hold_for_drain;
  } beam_req_t;

  typedef struct {
    kind_t                     kind;
    logic [TAG_W-1:0]          tag;
    logic signed [SCORE_W-1:0] score;
    logic                      kept;
    logic [CNT_W-1:0]          held;
    logic [CNT_W-1:0]          distinct;
    logic                      last;
  } beam_result_t;

  logic                      clk;
  logic                      rst_n;
  logic                      start;
  logic                      busy;
  logic                      in_op;
  logic [TAG_W-1:0]          in_item_tag;
  logic signed [SCORE_W-1:0] in_score;
  logic [INST_BITS-1:0]      in_instance_count;
  logic                      out_valid;
  logic [KIND_BITS-1:0]      out_kind;
  logic [TAG_W-1:0]          out_tag;
  logic signed [SCORE_W-1:0] out_score;
  logic                      out_new_kept;
  logic [CNT_W-1:0]          out_entry_count;
  logic [CNT_W-1:0]          out_distinct_count;
  logic                      out_last;
  logic                      psel;
  logic                      penable;
  logic                      pwrite;
  logic [CFG_ADDR_BITS-1:0]  paddr;
  logic [CFG_DATA_BITS-1:0]  pwdata;
  logic [CFG_DATA_BITS-1:0]  prdata;
  logic                      pready;

  bounded_sorted_beam_queue_core u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_op              (in_op),
    .in_item_tag        (in_item_tag),
    .in_score           (in_score),
    .in_instance_count  (in_instance_count),
    .out_valid          (out_valid),
    .out_kind           (out_kind),
    .out_tag            (out_tag),
    .out_score          (out_score),
    .out_new_kept       (out_new_kept),
    .out_entry_count    (out_entry_count),
    .out_distinct_count (out_distinct_count),
    .out_last           (out_last),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready)
  );

  // ---------------------------------------------------------------------
  // Shadow beam: contents, counts and register copies kept in step with
  // every accepted request.
  // ---------------------------------------------------------------------
  logic [TAG_W-1:0]          beam_tag   [0:BEAM_DEPTH];
  logic signed [SCORE_W-1:0] beam_score [0:BEAM_DEPTH];
  int                        beam_len;
  int                        beam_distinct;
  logic [LIMIT_BITS-1:0]     shadow_limit;
  logic                      shadow_by_distinct;
  logic [INST_BITS-1:0]      shadow_min_inst;

  beam_req_t    pending_reqs[$];
  beam_result_t due_results[$];
  beam_req_t    cur_req;

  int  gap_left;
  bit  burst_mode;
  int  fail_count;
  int  cycle_count;
  int  insert_count;
  int  pop_count;
  int  checked_count;
  int  setting_count;
  int  kind_seen [0:7];

  always #5 clk = ~clk;

  // distinct scores among the first n held entries
  function automatic int distinct_upto(int n);
    int d = 0;
    for (int i = 0; i < n; i++)
      if (i == 0 || beam_score[i] != beam_score[i-1]) d++;
    return d;
  endfunction

  function automatic beam_result_t make_result(kind_t k, logic [TAG_W-1:0] t,
                                               logic signed [SCORE_W-1:0] s);
    beam_result_t r;
    r.kind     = k;
    r.tag      = t;
    r.score    = s;
    r.kept     = 1'b0;
    r.held     = '0;
    r.distinct = '0;
    r.last     = 1'b0;
    return r;
  endfunction

  // Apply one request to the shadow beam and queue the results it causes.
  task automatic beam_update(input beam_req_t r);
    beam_result_t step_out[$];
    beam_result_t res;
    int           lim;
    int           pos;
    int           grp;
    bit           kept;
    kept = 1'b0;
    if (r.op == OP_POP) begin
      if (beam_len == 0) begin
        step_out.push_back(make_result(K_EMPTY, '0, '0));
      end else begin
        step_out.push_back(make_result(K_POPPED, beam_tag[0], beam_score[0]));
        for (int i = 1; i < beam_len; i++) begin
          beam_tag[i-1]   = beam_tag[i];
          beam_score[i-1] = beam_score[i];
        end
        beam_len--;
      end
    end else begin
      // zero limit behaves as one
      lim = (shadow_limit == 0) ? 1 : int'(shadow_limit);
      pos = 0;
      while (pos < beam_len && beam_score[pos] > r.score) pos++;
      if (r.inst < shadow_min_inst) begin
        step_out.push_back(make_result(K_BELOW, r.tag, r.score));
      end else if (shadow_by_distinct && distinct_upto(pos) >= lim) begin
        step_out.push_back(make_result(K_BEYOND, r.tag, r.score));
      end else begin
        // new entry goes ahead of any equal score
        for (int i = beam_len; i > pos; i--) begin
          beam_tag[i]   = beam_tag[i-1];
          beam_score[i] = beam_score[i-1];
        end
        beam_tag[pos]   = r.tag;
        beam_score[pos] = r.score;
        beam_len++;
        kept = 1'b1;
        step_out.push_back(make_result(K_STORED, r.tag, r.score));
        if (!shadow_by_distinct) begin
          // entry mode trims just one tail entry, even after a lowered limit
          if (beam_len > lim) begin
            beam_len--;
            if (pos == beam_len) kept = 1'b0;
            step_out.push_back(make_result(K_EVICTED, beam_tag[beam_len],
                                           beam_score[beam_len]));
          end
        end else if (distinct_upto(beam_len) > lim) begin
          // drop the whole lowest-score group
          grp = beam_len - 1;
          while (grp > 0 && beam_score[grp-1] == beam_score[grp]) grp--;
          if (pos >= grp) kept = 1'b0;
          for (int i = grp; i < beam_len; i++)
            step_out.push_back(make_result(K_EVICTED, beam_tag[i], beam_score[i]));
          beam_len = grp;
        end
        // physical store overflow
        if (beam_len > BEAM_DEPTH) begin
          beam_len--;
          if (pos == beam_len) kept = 1'b0;
          step_out.push_back(make_result(K_EVICTED, beam_tag[beam_len],
                                         beam_score[beam_len]));
        end
      end
    end
    beam_distinct = distinct_upto(beam_len);
    for (int k = 0; k < step_out.size(); k++) begin
      res          = step_out[k];
      res.kept     = kept;
      res.held     = CNT_W'(beam_len);
      res.distinct = CNT_W'(beam_distinct);
      res.last     = (k == step_out.size() - 1);
      due_results.push_back(res);
    end
  endtask

  // ---------------------------------------------------------------------
  // Request driver: takes requests from pending_reqs, draws an idle gap at
  // random after each one, sometimes runs back-to-back bursts.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    bit start_nxt;
    start_nxt = start;
    if (!rst_n) begin
      start_nxt = 1'b0;
      gap_left  = 0;
    end else begin
      if (start && !busy) begin
        beam_update(cur_req);
        if (cur_req.op == OP_POP) pop_count++;
        else insert_count++;
        start_nxt = 1'b0;
        gap_left  = burst_mode ? 0 : $urandom_range(0, 3);
        if ($urandom_range(0, 15) == 0) burst_mode = !burst_mode;
      end else if (!start && gap_left > 0) begin
        gap_left--;
      end
      if (!start_nxt && gap_left == 0 && pending_reqs.size() != 0 &&
          (!pending_reqs[0].hold_for_drain ||
           (due_results.size() == 0 && !busy))) begin
        cur_req = pending_reqs.pop_front();
        in_op             <= cur_req.op;
        in_item_tag       <= cur_req.tag;
        in_score          <= cur_req.score;
        in_instance_count <= cur_req.inst;
        start_nxt = 1'b1;
      end
    end
    start <= start_nxt;
  end

  // ---------------------------------------------------------------------
  // Result monitor: every strobe is matched against the oldest prediction.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    beam_result_t exp_r;
    if (rst_n && out_valid) begin
      if (due_results.size() == 0) begin
        $error("unexpected result: kind %0d tag 0x%04h score %0d",
               out_kind, out_tag, out_score);
        fail_count++;
      end else begin
        exp_r = due_results.pop_front();
        checked_count++;
        kind_seen[exp_r.kind]++;
        if (out_kind !== exp_r.kind) begin
          $error("kind: expected %0d, actual %0d", exp_r.kind, out_kind);
          fail_count++;
        end
        if (out_tag !== exp_r.tag) begin
          $error("out_tag: expected 0x%04h, actual 0x%04h", exp_r.tag, out_tag);
          fail_count++;
        end
        if (out_score !== exp_r.score) begin
          $error("out_score: expected %0d, actual %0d", exp_r.score, out_score);
          fail_count++;
        end
        if (out_new_kept !== exp_r.kept) begin
          $error("new_kept: expected %0d, actual %0d", exp_r.kept, out_new_kept);
          fail_count++;
        end
        if (out_entry_count !== exp_r.held) begin
          $error("entry_count: expected %0d, actual %0d", exp_r.held, out_entry_count);
          fail_count++;
        end
        if (out_distinct_count !== exp_r.distinct) begin
          $error("distinct_count: expected %0d, actual %0d",
                 exp_r.distinct, out_distinct_count);
          fail_count++;
        end
        if (out_last !== exp_r.last) begin
          $error("last: expected %0d, actual %0d", exp_r.last, out_last);
          fail_count++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_count, due_results.size());
      $display("FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------
  task automatic add_insert(input logic [TAG_W-1:0] tag,
                            input logic signed [SCORE_W-1:0] score,
                            input logic [INST_BITS-1:0] inst);
    beam_req_t r;
    r.op = OP_INSERT;
    r.tag = tag;
    r.score = score;
    r.inst = inst;
    r.hold_for_drain = 1'b0;
    pending_reqs.push_back(r);
  endtask

  task automatic add_pop();
    beam_req_t r;
    r.op = OP_POP;
    r.tag = TAG_W'($urandom);
    r.score = SCORE_W'($urandom);
    r.inst = INST_BITS'($urandom);
    r.hold_for_drain = 1'b0;
    pending_reqs.push_back(r);
  endtask

  // Block until nothing is queued, in flight or owed; the outer loop
  // catches a request that got launched on the very edge we looked.
  task automatic wait_idle();
    do begin
      while (pending_reqs.size() != 0 || start || busy || due_results.size() != 0)
        @(posedge clk);
      repeat (SETTLE_CYCLES) @(posedge clk);
    end while (pending_reqs.size() != 0 || start || busy || due_results.size() != 0);
  endtask

  // APB write: setup cycle, then access cycle
  task automatic write_reg(input logic [REG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_BEAM_LIMIT:    shadow_limit       = val[LIMIT_BITS-1:0];
      REG_LIMIT_BY_DIST: shadow_by_distinct = val[0];
      REG_MIN_INST:      shadow_min_inst    = val[INST_BITS-1:0];
      default: ;
    endcase
  endtask

  task automatic set_beam_config(input int limit, input bit by_distinct,
                                 input int min_inst);
    wait_idle();
    write_reg(REG_BEAM_LIMIT, CFG_DATA_BITS'(limit));
    write_reg(REG_LIMIT_BY_DIST, CFG_DATA_BITS'(by_distinct));
    write_reg(REG_MIN_INST, CFG_DATA_BITS'(min_inst));
    setting_count++;
  endtask

  // narrow pool gives ties and group evictions, wide style mostly distinct
  function automatic logic signed [SCORE_W-1:0] pick_score(bit wide);
    logic signed [SCORE_W-1:0] pool [0:5];
    pool[0] = SCORE_MAX;
    pool[1] = SCORE_MIN;
    pool[2] = '0;
    pool[3] = 32'sh0001_0000;
    pool[4] = -32'sh0001_0000;
    pool[5] = 32'sh0000_8000;
    case ($urandom_range(0, 9))
      0:       return SCORE_MAX;
      1:       return SCORE_MIN;
      2, 3:    return wide ? SCORE_W'($urandom) : pool[$urandom_range(0, 5)];
      default: return wide ? SCORE_W'($urandom)
                           : SCORE_W'(int'($urandom_range(0, 4)) - 2) <<< 16;
    endcase
  endfunction

  // instance counts cluster on the threshold so both sides of it show up
  function automatic logic [INST_BITS-1:0] pick_inst();
    int m;
    m = int'(shadow_min_inst);
    case ($urandom_range(0, 7))
      0:       return INST_BITS'(m);
      1:       return INST_BITS'((m > 0) ? m - 1 : 0);
      2:       return INST_BITS'($urandom);
      default: return INST_BITS'($urandom_range(m, 65535));
    endcase
  endfunction

  task automatic queue_random_reqs(input int count, input int pop_pct, input bit wide);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < pop_pct) add_pop();
      else add_insert(TAG_W'($urandom), pick_score(wide), pick_inst());
      if ($urandom_range(0, 19) == 0) pending_reqs[$].hold_for_drain = 1'b1;
    end
  endtask

  // ---------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------
  initial begin
    clk               = 1'b0;
    rst_n             = 1'b0;
    start             = 1'b0;
    in_op             = OP_INSERT;
    in_item_tag       = '0;
    in_score          = '0;
    in_instance_count = '0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    beam_len          = 0;
    beam_distinct     = 0;
    shadow_limit       = BEAM_LIMIT_RST;
    shadow_by_distinct = LIMIT_BY_DIST_RST;
    shadow_min_inst    = MIN_INST_RST;
    gap_left          = 0;
    burst_mode        = 1'b0;
    fail_count        = 0;
    cycle_count       = 0;
    insert_count      = 0;
    pop_count         = 0;
    checked_count     = 0;
    setting_count     = 1;
    for (int k = 0; k < 8; k++) kind_seen[k] = 0;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed, reset registers: limit 4 by entries, no minimum
    add_pop();                                   // empty beam
    add_insert(16'hffff, SCORE_MAX, 16'hffff);
    add_insert(16'h0000, SCORE_MIN, 16'h0000);
    add_insert(16'h1111, 32'sh0, 16'd5);
    add_insert(16'h2222, 32'sh0, 16'd5);        // ties: lands ahead of 1111
    add_insert(16'h3333, -32'sd100, 16'd5);      // overflows, tail dropped
    add_insert(16'h4444, -32'sd200, 16'd5);      // new item is the tail itself
    add_pop();

    // limit lowered below the fill level, with an instance threshold
    set_beam_config(2, 1'b0, 100);
    add_insert(16'h5555, 32'sh0001_0000, 16'd99);  // below minimum
    add_insert(16'h5556, 32'sh0001_0000, 16'd100); // only one entry dropped
    add_insert(16'h5557, 32'sh7fff_0000, 16'hffff);

    // distinct-score mode
    set_beam_config(2, 1'b1, 0);
    add_insert(16'h6000, SCORE_MIN, 16'd1);      // behind too many scores
    add_insert(16'h6001, 32'sh7fff_0000, 16'd1);
    add_insert(16'h6002, 32'sh0002_0000, 16'd1); // lowest group goes
    add_pop();

    // zero limit acts as one
    set_beam_config(0, 1'b1, 0);
    add_insert(16'h7000, 32'sh0003_0000, 16'd7);
    add_insert(16'h7001, 32'sh0003_0000, 16'd7);
    add_insert(16'h7002, 32'sh0004_0000, 16'd7); // rejected, beyond beam, like both ties
    add_insert(16'h7003, 32'sh0000_1000, 16'd7); // rejected, beyond beam
    add_pop();
    add_pop();
    add_pop();

    // random phases over a spread of register settings
    set_beam_config(16, 1'b0, 0);      queue_random_reqs(16, 15, 1'b0);
    set_beam_config(31, 1'b0, 0);      queue_random_reqs(22, 5, 1'b1);  // store overflow
    set_beam_config(1, 1'b0, 0);       queue_random_reqs(10, 20, 1'b0);
    set_beam_config(0, 1'b0, 0);       queue_random_reqs(8, 20, 1'b0);
    set_beam_config(3, 1'b1, 0);       queue_random_reqs(18, 20, 1'b0);
    set_beam_config(16, 1'b1, 0);      queue_random_reqs(16, 10, 1'b0);
    set_beam_config(20, 1'b1, 0);      queue_random_reqs(22, 5, 1'b1);  // store overflow
    set_beam_config(2, 1'b0, 1234);    queue_random_reqs(14, 20, 1'b0);
    set_beam_config(0, 1'b1, 65535);   queue_random_reqs(10, 20, 1'b0);
    set_beam_config(5, 1'b1, 300);     queue_random_reqs(16, 25, 1'b0);

    wait_idle();
    $display("Ran %0d inserts and %0d pops under %0d register settings, %0d results checked",
             insert_count, pop_count, setting_count, checked_count);
    $display("Result kinds: stored %0d, below %0d, beyond %0d, evicted %0d, popped %0d, empty %0d",
             kind_seen[K_STORED], kind_seen[K_BELOW], kind_seen[K_BEYOND],
             kind_seen[K_EVICTED], kind_seen[K_POPPED], kind_seen[K_EMPTY]);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
